>>> rtl/dltq_pkg.sv
// package for the delta list timer queue
// types, field widths and codes shared by all rtl files; no dependencies
package dltq_pkg;
  localparam int NUM_TIMERS_DEF = 16;
  localparam int TIME_BITS_DEF  = 16;
  localparam int ID_BITS_DEF    = 16;
  localparam int TAG_BITS_DEF   = 8;

  localparam int OP_W    = 2;
  localparam int DLY_W   = 16;
  localparam int TID_W   = 16;
  localparam int ETAG_W  = 8;
  localparam int KIND_W  = 3;
  localparam int STAT_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_SET = 2'd0, OP_CLR = 2'd1, OP_GET = 2'd2, OP_AGE = 2'd3
  } op_t;

  localparam logic [KIND_W-1:0] KIND_SET = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CLR = 3'd1;
  localparam logic [KIND_W-1:0] KIND_GET = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EXP = 3'd3;
  localparam logic [KIND_W-1:0] KIND_AGE = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_NF   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DLY_W-1:0]  delay;
    logic [DLY_W-1:0]  elapsed;
    logic [TID_W-1:0]  query_id;
    logic [ETAG_W-1:0] event_tag;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [STAT_W-1:0] status;
    logic [15:0]       id_out;
    logic [15:0]       remaining;
    logic [7:0]        tag_out;
    logic [15:0]       next_delay;
    logic              queue_empty;
    logic              last;
  } out_item_t;

  // per-cell commands broadcast by the controller
  typedef enum logic [2:0] {
    CC_HOLD  = 3'd0, // keep contents
    CC_INS   = 3'd1, // insert new timer at its ordered place
    CC_DEL   = 3'd2, // remove matched cell, close gap
    CC_POP   = 3'd3, // remove head, shift all left
    CC_SUBH  = 3'd4  // subtract sub_time from every cell
  } cell_cmd_t;
endpackage

>>> rtl/dltq_if.sv
// valid/ready channel interface carrying one payload type
// uses dltq_pkg for payload structs
interface dltq_in_if;
  import dltq_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dltq_out_if;
  import dltq_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/delta_list_timer_queue_unit.sv
// top level of the delta list timer queue: controller, cell chain, output register
// depends on dltq_pkg, dltq_if (dltq_in_if, dltq_out_if), dltq_chain
//
//  channel | dir | handshake        | payload
//  in      | in  | in.valid/ready   | op, delay, elapsed, query_id, event_tag
//  out     | out | out.valid/ready  | kind, status, id_out, remaining, tag_out,
//          |     |                  | next_delay, queue_empty, last
//
// set, clear and get go from accept to result register via load, cell update and
// answer; age loads, then pops expired timers off the chain head one cell per cycle
// unless out.ready stalls, then answers. one transaction is in work at a time.
// reset (rst_n low, synchronous) empties all cells and zeroes the id counter.
// a stalled out.ready holds the result register and pauses the age sequence.
module delta_list_timer_queue_unit #(
  parameter int NUM_TIMERS = dltq_pkg::NUM_TIMERS_DEF,
  parameter int TIME_BITS  = dltq_pkg::TIME_BITS_DEF,
  parameter int ID_BITS    = dltq_pkg::ID_BITS_DEF,
  parameter int TAG_BITS   = dltq_pkg::TAG_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  dltq_in_if.sink    in_ch,
  dltq_out_if.source out_ch
);
  import dltq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_EXEC = 5'b00010, S_ANS = 5'b00100,
    S_AGE  = 5'b01000, S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  in_item_t req_r;
  logic [ID_BITS-1:0]   id_cnt_r, id_cnt_nxt;
  logic [TIME_BITS-1:0] elap_r, elap_nxt;      // ticks still to take off during age
  logic [TIME_BITS-1:0] base_r, base_nxt;      // ticks already removed from head
  logic [ID_BITS-1:0]   new_id_r, new_id_nxt;
  logic [STAT_W-1:0]    stat_r, stat_nxt;
  logic [TIME_BITS-1:0] rem_r, rem_nxt;
  out_item_t ob_r, ob_nxt;
  logic      ov_r, ov_nxt;

  // chain signals
  cell_cmd_t            cmd;
  logic [TIME_BITS-1:0] new_time, sub_time;
  logic [NUM_TIMERS-1:0] del_mask, valid, hit;
  logic [TIME_BITS-1:0] time_q [NUM_TIMERS];
  logic [ID_BITS-1:0]   id_q   [NUM_TIMERS];
  logic [TAG_BITS-1:0]  tag_q  [NUM_TIMERS];

  // cells hold absolute times relative to the last completed age
  dltq_chain #(.NUM_TIMERS(NUM_TIMERS), .TIME_BITS(TIME_BITS), .ID_BITS(ID_BITS),
               .TAG_BITS(TAG_BITS)) u_chain (
    .clk, .rst_n, .cmd, .new_time,
    .new_id(new_id_r), .new_tag(TAG_BITS'(req_r.event_tag)), .sub_time,
    .match_id(ID_BITS'(req_r.query_id)), .del_mask,
    .valid, .hit, .time_q, .id_q, .tag_q);

  // delay saturates to the time width
  always_comb begin
    if (TIME_BITS < DLY_W && (req_r.delay >> TIME_BITS) != '0) new_time = '1;
    else new_time = TIME_BITS'(req_r.delay);
  end

  // removal mask: first hit and everything after it
  logic [NUM_TIMERS-1:0] first_hit, clr_mask;
  logic                  any_hit;
  always_comb begin
    clr_mask = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      clr_mask[i] = hit[i] || ((i > 0) ? clr_mask[(i > 0) ? i-1 : 0] : 1'b0);
    end
    first_hit = hit & ~(clr_mask << 1);
    any_hit   = |hit;
  end

  // absolute time of the first hit, one-hot select
  logic [TIME_BITS-1:0] hit_time;
  always_comb begin
    hit_time = '0;
    for (int i = 0; i < NUM_TIMERS; i++) if (first_hit[i]) hit_time = hit_time | time_q[i];
  end

  wire full      = valid[NUM_TIMERS-1];
  wire id_zero   = (req_r.query_id == '0);
  wire head_v    = valid[0];
  wire [TIME_BITS-1:0] head_t = time_q[0];
  wire out_free  = !ov_r || out_ch.ready;

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    id_cnt_nxt = id_cnt_r;
    elap_nxt   = elap_r;
    base_nxt   = base_r;
    new_id_nxt = new_id_r;
    stat_nxt   = stat_r;
    rem_nxt    = rem_r;
    ob_nxt     = ob_r;
    ov_nxt     = ov_r && !out_ch.ready;
    cmd        = CC_HOLD;
    sub_time   = '0;
    del_mask   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        stat_nxt = ST_OK;
        rem_nxt  = '0;
        new_id_nxt = '0;
        priority case (op_t'(req_r.op))
          OP_SET: begin
            if (full) stat_nxt = ST_FULL;
            else begin
              id_cnt_nxt = (id_cnt_r + 1'b1 == '0) ? ID_BITS'(1) : id_cnt_r + 1'b1;
              new_id_nxt = id_cnt_nxt;
            end
            state_nxt = S_ANS;
          end
          OP_CLR, OP_GET: begin
            if (id_zero || !any_hit) stat_nxt = ST_NF;
            else if (req_r.op == OP_GET) rem_nxt = hit_time;
            state_nxt = S_ANS;
          end
          default: begin
            elap_nxt  = TIME_BITS'(req_r.elapsed);
            base_nxt  = '0;
            state_nxt = S_AGE;
          end
        endcase
      end
      S_ANS: begin
        // cell update happens here; answer reads the chain next cycle
        if (req_r.op == OP_SET && stat_r == ST_OK) cmd = CC_INS;
        if (req_r.op == OP_CLR && stat_r == ST_OK) begin
          cmd = CC_DEL; del_mask = clr_mask;
        end
        state_nxt = S_OUT;
      end
      S_AGE: begin
        if (out_free) begin
          if (head_v && (head_t - base_r) <= elap_r) begin
            // head expires: emit event, pop, keep track of removed ticks
            ob_nxt = '0;
            ob_nxt.kind    = KIND_EXP;
            ob_nxt.id_out  = 16'(id_q[0]);
            ob_nxt.tag_out = 8'(tag_q[0]);
            ov_nxt = 1'b1;
            elap_nxt = elap_r - (head_t - base_r);
            base_nxt = head_t;
            cmd = CC_POP; del_mask = '1; sub_time = '0;
          end else begin
            // take remaining ticks (and removed base) off every cell
            cmd = CC_SUBH;
            sub_time = head_v ? base_r + elap_r : '0;
            stat_nxt = ST_OK;
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          ob_nxt = '0;
          unique case (op_t'(req_r.op))
            OP_SET: ob_nxt.kind = KIND_SET;
            OP_CLR: ob_nxt.kind = KIND_CLR;
            OP_GET: ob_nxt.kind = KIND_GET;
            OP_AGE: ob_nxt.kind = KIND_AGE;
          endcase
          ob_nxt.status      = stat_r;
          ob_nxt.id_out      = 16'(new_id_r);
          ob_nxt.remaining   = 16'(rem_r);
          ob_nxt.next_delay  = head_v ? 16'(head_t) : 16'd0;
          ob_nxt.queue_empty = !head_v;
          ob_nxt.last        = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // cells subtract only on the whole chain: CC_SUBH applies to every cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      id_cnt_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      id_cnt_r <= id_cnt_nxt;
      ov_r     <= ov_nxt;
    end
    if (in_ch.valid && in_ch.ready) req_r <= in_ch.data;
    elap_r   <= elap_nxt;
    base_r   <= base_nxt;
    new_id_r <= new_id_nxt;
    stat_r   <= stat_nxt;
    rem_r    <= rem_nxt;
    ob_r     <= ob_nxt;
  end

  assign out_ch.valid = ov_r;
  assign out_ch.data  = ob_r;
endmodule

>>> rtl/dltq_cell.sv
// one timer cell of the chain; holds valid, absolute time, id and tag
// depends on dltq_pkg
module dltq_cell #(
  parameter int TIME_BITS = dltq_pkg::TIME_BITS_DEF,
  parameter int ID_BITS   = dltq_pkg::ID_BITS_DEF,
  parameter int TAG_BITS  = dltq_pkg::TAG_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dltq_pkg::cell_cmd_t  cmd,
  input  logic [TIME_BITS-1:0] new_time,
  input  logic [ID_BITS-1:0]   new_id,
  input  logic [TAG_BITS-1:0]  new_tag,
  input  logic [TIME_BITS-1:0] sub_time,
  input  logic                 del_here,   // this cell or one before is removed
  input  logic                 left_ins,   // left neighbor is above new time
  input  logic                 rn_valid,
  input  logic [TIME_BITS-1:0] rn_time,
  input  logic [ID_BITS-1:0]   rn_id,
  input  logic [TAG_BITS-1:0]  rn_tag,
  input  logic                 ln_valid,   // high for the head cell
  input  logic [TIME_BITS-1:0] ln_time,
  input  logic [ID_BITS-1:0]   ln_id,
  input  logic [TAG_BITS-1:0]  ln_tag,
  output logic                 valid,
  output logic [TIME_BITS-1:0] abs_time,
  output logic [ID_BITS-1:0]   id,
  output logic [TAG_BITS-1:0]  tag,
  output logic                 above      // holds a timer later than new_time
);
  import dltq_pkg::*;
  // cells keep absolute remaining time; deltas are formed by the controller
  logic                 valid_r, valid_nxt;
  logic [TIME_BITS-1:0] time_r, time_nxt;
  logic [ID_BITS-1:0]   id_r, id_nxt;
  logic [TAG_BITS-1:0]  tag_r, tag_nxt;

  assign above = valid_r && (time_r > new_time);

  always_comb begin
    valid_nxt = valid_r;
    time_nxt  = time_r;
    id_nxt    = id_r;
    tag_nxt   = tag_r;
    unique case (cmd)
      CC_INS: begin
        if (left_ins) begin
          valid_nxt = ln_valid; time_nxt = ln_time; id_nxt = ln_id; tag_nxt = ln_tag;
        end else if (above || (!valid_r && ln_valid)) begin
          // the first cell above the new time, or the first empty cell, takes the new timer
          valid_nxt = 1'b1; time_nxt = new_time; id_nxt = new_id; tag_nxt = new_tag;
        end
      end
      CC_DEL, CC_POP: begin
        if (del_here) begin
          valid_nxt = rn_valid; time_nxt = rn_time; id_nxt = rn_id; tag_nxt = rn_tag;
        end
        if (cmd == CC_POP) time_nxt = (del_here ? rn_time : time_r) - sub_time;
      end
      CC_SUBH: time_nxt = time_r - sub_time;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
    time_r <= time_nxt;
    id_r   <= id_nxt;
    tag_r  <= tag_nxt;
  end

  assign valid    = valid_r;
  assign abs_time = time_r;
  assign id       = id_r;
  assign tag      = tag_r;
endmodule

>>> rtl/dltq_chain.sv
// row of timer cells with neighbor links and per-cell match flags
// depends on dltq_pkg and dltq_cell
module dltq_chain #(
  parameter int NUM_TIMERS = dltq_pkg::NUM_TIMERS_DEF,
  parameter int TIME_BITS  = dltq_pkg::TIME_BITS_DEF,
  parameter int ID_BITS    = dltq_pkg::ID_BITS_DEF,
  parameter int TAG_BITS   = dltq_pkg::TAG_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dltq_pkg::cell_cmd_t  cmd,
  input  logic [TIME_BITS-1:0] new_time,
  input  logic [ID_BITS-1:0]   new_id,
  input  logic [TAG_BITS-1:0]  new_tag,
  input  logic [TIME_BITS-1:0] sub_time,
  input  logic [ID_BITS-1:0]   match_id,
  input  logic [NUM_TIMERS-1:0] del_mask,  // cells at or after removal point
  output logic [NUM_TIMERS-1:0] valid,
  output logic [NUM_TIMERS-1:0] hit,       // valid cell with matching id
  output logic [TIME_BITS-1:0] time_q [NUM_TIMERS],
  output logic [ID_BITS-1:0]   id_q   [NUM_TIMERS],
  output logic [TAG_BITS-1:0]  tag_q  [NUM_TIMERS]
);
  import dltq_pkg::*;
  logic [NUM_TIMERS-1:0] above;

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    logic                 rv, lv, li;
    logic [TIME_BITS-1:0] rt, lt;
    logic [ID_BITS-1:0]   ri, lid;
    logic [TAG_BITS-1:0]  rtg, ltg;
    if (g == NUM_TIMERS-1) begin : g_r_end
      assign rv = 1'b0; assign rt = '0; assign ri = '0; assign rtg = '0;
    end else begin : g_r
      assign rv = valid[g+1]; assign rt = time_q[g+1];
      assign ri = id_q[g+1];  assign rtg = tag_q[g+1];
    end
    if (g == 0) begin : g_l_end
      // head cell sees a filled left side so it can take the first timer
      assign lv = 1'b1; assign lt = '0; assign lid = '0; assign ltg = '0; assign li = 1'b0;
    end else begin : g_l
      assign lv = valid[g-1]; assign lt = time_q[g-1];
      assign lid = id_q[g-1]; assign ltg = tag_q[g-1]; assign li = above[g-1];
    end
    dltq_cell #(.TIME_BITS(TIME_BITS), .ID_BITS(ID_BITS), .TAG_BITS(TAG_BITS)) u_cell (
      .clk, .rst_n, .cmd, .new_time, .new_id, .new_tag, .sub_time,
      .del_here(del_mask[g]), .left_ins(li),
      .rn_valid(rv), .rn_time(rt), .rn_id(ri), .rn_tag(rtg),
      .ln_valid(lv), .ln_time(lt), .ln_id(lid), .ln_tag(ltg),
      .valid(valid[g]), .abs_time(time_q[g]), .id(id_q[g]), .tag(tag_q[g]),
      .above(above[g]));
    assign hit[g] = valid[g] && (id_q[g] == match_id);
  end
endmodule

>>> verif/delta_list_timer_queue_unit_test.sv
// testbench for delta_list_timer_queue_unit: drives timer operations, predicts
// every result with a delta-list model of its own and checks them in order
// depends on dltq_pkg, dltq_if and the rtl top level
`timescale 1ns / 100ps

// scoreboard: timer queue predictor plus the store of pending expected results
class timer_scoreboard;
  localparam int CAP = dltq_pkg::NUM_TIMERS_DEF;
  bit [15:0] dlt [CAP];
  bit [15:0] ids [CAP];
  bit [7:0]  tags[CAP];
  int        cnt;
  bit [15:0] next_id;
  dltq_pkg::out_item_t pending_results[$];
  int        mismatches;

  function new();
    cnt = 0;
    next_id = '0;
    mismatches = 0;
  endfunction

  function void push_result(logic [2:0] k, logic [1:0] st, logic [15:0] idv,
                            logic [15:0] rm, logic [7:0] tg, bit fin);
    dltq_pkg::out_item_t r;
    r.kind = k; r.status = st; r.id_out = idv; r.remaining = rm; r.tag_out = tg;
    r.next_delay = (fin && cnt > 0) ? dlt[0] : 16'd0;
    r.queue_empty = fin && cnt == 0;
    r.last = fin;
    pending_results.push_back(r);
  endfunction

  function int locate(bit [15:0] idv, output bit [15:0] total);
    bit [16:0] acc;
    acc = 0;
    total = 0;
    for (int i = 0; i < cnt; i++) begin
      acc += dlt[i];
      if (ids[i] == idv) begin
        total = acc[15:0];
        return i;
      end
    end
    return -1;
  endfunction

  function void drop_at(int p);
    for (int i = p; i + 1 < cnt; i++) begin
      dlt[i] = dlt[i+1]; ids[i] = ids[i+1]; tags[i] = tags[i+1];
    end
    cnt--;
  endfunction

  // note an accepted input transaction and predict its results
  function void note_input(dltq_pkg::in_item_t it);
    bit [15:0] d, tot;
    int p;
    bit [16:0] e;
    tot = 0;
    case (dltq_pkg::op_t'(it.op))
      dltq_pkg::OP_SET: begin
        if (cnt >= CAP) begin
          push_result(dltq_pkg::KIND_SET, dltq_pkg::ST_FULL, 0, 0, 0, 1);
        end else begin
          next_id = next_id + 16'd1;
          if (next_id == 0) next_id = 1;
          d = it.delay;
          p = 0;
          while (p < cnt && d >= dlt[p]) begin
            d -= dlt[p];
            p++;
          end
          if (p < cnt) dlt[p] -= d;
          for (int i = cnt; i > p; i--) begin
            dlt[i] = dlt[i-1]; ids[i] = ids[i-1]; tags[i] = tags[i-1];
          end
          dlt[p] = d; ids[p] = next_id; tags[p] = it.event_tag;
          cnt++;
          push_result(dltq_pkg::KIND_SET, dltq_pkg::ST_OK, next_id, 0, 0, 1);
        end
      end
      dltq_pkg::OP_CLR, dltq_pkg::OP_GET: begin
        p = (it.query_id == 0) ? -1 : locate(it.query_id, tot);
        if (p < 0) begin
          push_result(it.op, dltq_pkg::ST_NF, 0, 0, 0, 1);
        end else if (it.op == dltq_pkg::OP_CLR) begin
          if (p + 1 < cnt) dlt[p+1] += dlt[p];
          drop_at(p);
          push_result(dltq_pkg::KIND_CLR, dltq_pkg::ST_OK, 0, 0, 0, 1);
        end else begin
          push_result(dltq_pkg::KIND_GET, dltq_pkg::ST_OK, 0, tot, 0, 1);
        end
      end
      default: begin
        e = it.elapsed;
        while (cnt > 0) begin
          if (dlt[0] > e) begin
            dlt[0] -= e[15:0];
            break;
          end
          e -= dlt[0];
          push_result(dltq_pkg::KIND_EXP, dltq_pkg::ST_OK, ids[0], 0, tags[0], 0);
          drop_at(0);
        end
        push_result(dltq_pkg::KIND_AGE, dltq_pkg::ST_OK, 0, 0, 0, 1);
      end
    endcase
  endfunction

  function void report(string what);
    $display("mismatch: %s", what);
    mismatches++;
  endfunction

  // compare an accepted result with the oldest expectation
  function void check_result(dltq_pkg::out_item_t got);
    dltq_pkg::out_item_t exp_r;
    if (pending_results.size() == 0) begin
      report($sformatf("unexpected result %p", got));
      return;
    end
    exp_r = pending_results.pop_front();
    if (got.kind !== exp_r.kind) report($sformatf("kind %0d want %0d", got.kind, exp_r.kind));
    if (got.status !== exp_r.status)
      report($sformatf("status %0d want %0d", got.status, exp_r.status));
    if (got.id_out !== exp_r.id_out)
      report($sformatf("id_out %0d want %0d", got.id_out, exp_r.id_out));
    if (got.remaining !== exp_r.remaining)
      report($sformatf("remaining %0d want %0d", got.remaining, exp_r.remaining));
    if (got.tag_out !== exp_r.tag_out)
      report($sformatf("tag_out %0d want %0d", got.tag_out, exp_r.tag_out));
    if (got.next_delay !== exp_r.next_delay)
      report($sformatf("next_delay %0d want %0d", got.next_delay, exp_r.next_delay));
    if (got.queue_empty !== exp_r.queue_empty)
      report($sformatf("queue_empty %0d want %0d", got.queue_empty, exp_r.queue_empty));
    if (got.last !== exp_r.last)
      report($sformatf("last %0d want %0d", got.last, exp_r.last));
  endfunction
endclass

module delta_list_timer_queue_unit_test;
  import dltq_pkg::*;

  logic clk;
  logic rst_n;
  dltq_in_if  in_ch();
  dltq_out_if out_ch();

  // idling controls, percent of cycles spent idle / stalled
  int send_idle_pct;
  int recv_stall_pct;
  timer_scoreboard timer_sb;
  // recently issued ids, so clear/get usually hit live timers
  bit [15:0] recent_ids[$];
  bit [15:0] last_issued;

  delta_list_timer_queue_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver: random stall, check every accepted result transaction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) timer_sb.check_result(out_ch.data);
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // keep the id history of successful sets small
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready && out_ch.data.kind == KIND_SET &&
        out_ch.data.status == ST_OK) begin
      recent_ids.push_back(out_ch.data.id_out);
      if (recent_ids.size() > 24) void'(recent_ids.pop_front());
    end
  end

  // send one transaction, with an optional idle gap ahead of it
  // valid stays high between back-to-back transactions
  task automatic send_item(in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= in_item_t'($urandom);
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    timer_sb.note_input(it);
  endtask

  task automatic send_op(op_t o, bit [15:0] dly, bit [15:0] ela, bit [15:0] tid,
                         bit [7:0] tg);
    in_item_t it;
    it.op = o; it.delay = dly; it.elapsed = ela; it.query_id = tid; it.event_tag = tg;
    send_item(it);
  endtask

  // pick an id: mostly a recently issued one, sometimes fresh noise or zero
  function automatic bit [15:0] pick_id();
    int r;
    r = $urandom_range(99);
    if (r < 70 && recent_ids.size() > 0) return recent_ids[$urandom_range(recent_ids.size()-1)];
    if (r < 80) return 16'd0;
    return 16'($urandom);
  endfunction

  // weighted delay: small values for collisions, some wide ones
  function automatic bit [15:0] pick_delay();
    case ($urandom_range(3))
      0: return 16'($urandom_range(4));
      1: return 16'($urandom_range(64));
      2: return 16'($urandom_range(1000));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic bit [15:0] pick_elapsed();
    case ($urandom_range(4))
      0: return 16'd0;
      1: return 16'($urandom_range(8));
      2: return 16'($urandom_range(300));
      3: return 16'($urandom_range(3000));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 40) send_op(OP_SET, pick_delay(), 16'($urandom), 16'($urandom), 8'($urandom));
    else if (r < 55) send_op(OP_CLR, 16'($urandom), 16'($urandom), pick_id(), 8'($urandom));
    else if (r < 72) send_op(OP_GET, 16'($urandom), 16'($urandom), pick_id(), 8'($urandom));
    else send_op(OP_AGE, 16'($urandom), pick_elapsed(), 16'($urandom), 8'($urandom));
  endtask

  // release the input, then wait until every expected result transaction has arrived
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (timer_sb.pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    timer_sb = new();
    rst_n = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-queue cases, id zero, unknown id, extremes
    send_op(OP_AGE, 16'h0000, 16'hffff, 16'h0000, 8'h00);
    send_op(OP_GET, 16'hffff, 16'h0000, 16'h0000, 8'hff);
    send_op(OP_CLR, 16'h0000, 16'hffff, 16'hffff, 8'h00);
    send_op(OP_SET, 16'hffff, 16'h0000, 16'h0000, 8'hff);
    send_op(OP_SET, 16'h0000, 16'hffff, 16'hffff, 8'h00);
    send_op(OP_SET, 16'd100, 16'd0, 16'd0, 8'h5a);
    send_op(OP_SET, 16'd100, 16'd0, 16'd0, 8'ha5); // equal time goes after
    send_op(OP_GET, 16'd0, 16'd0, 16'd4, 8'd0);
    send_op(OP_GET, 16'd0, 16'd0, 16'd1, 8'd0);
    send_op(OP_CLR, 16'd0, 16'd0, 16'd3, 8'd0);
    send_op(OP_GET, 16'd0, 16'd0, 16'd4, 8'd0);
    // fill the queue, then overflow it
    for (int i = 0; i < 14; i++) send_op(OP_SET, 16'(i * 37), 16'd0, 16'd0, 8'(i));
    send_op(OP_SET, 16'd5, 16'd0, 16'd0, 8'd1);
    // elapsed beyond all timers: everything expires at once
    send_op(OP_AGE, 16'd0, 16'hffff, 16'd0, 8'd0);
    send_op(OP_AGE, 16'd0, 16'd1, 16'd0, 8'd0);
    drain();

    // random phases: none, slow sender, slow receiver, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 85 : (ph == 3) ? 19 : 0;
      recv_stall_pct = (ph == 2) ? 85 : (ph == 3) ? 19 : 0;
      for (int n = 0; n < 90; n++) random_item();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;

    // set/age pairs: single timers that expire right away
    for (int n = 0; n < 40; n++) begin
      send_op(OP_SET, 16'($urandom_range(50)), 16'd0, 16'd0, 8'($urandom));
      send_op(OP_AGE, 16'd0, 16'hffff, 16'd0, 8'd0);
    end
    drain();

    repeat (20) @(posedge clk);
    if (timer_sb.mismatches == 0 && timer_sb.pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end
endmodule

>>> delta_list_timer_queue_unit.f
rtl/dltq_pkg.sv
rtl/dltq_if.sv
rtl/dltq_cell.sv
rtl/dltq_chain.sv
rtl/delta_list_timer_queue_unit.sv
verif/delta_list_timer_queue_unit_test.sv
